>>> hw/rtl/sliding_window_sender_top_defines.svh
// Assertion macros for the sliding window sender.
// Included by sliding_window_sender_top.sv; depends on nothing else.
`ifndef SLIDING_WINDOW_SENDER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SWS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sliding window sender assertion failed");
`define SWS_NEVER(lbl, clk, rst, expr) `SWS_ASSERT(lbl, clk, rst, !(expr))
`else
`define SWS_ASSERT(lbl, clk, rst, prop)
`define SWS_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> hw/rtl/swsnd_pkg.sv
// Types and constants shared by the sliding window sender modules.
// No dependencies.
package swsnd_pkg;

  localparam int SEQ_SPACE = 8;
  localparam int SEQ_W     = 3;
  localparam int PAY_W     = 32;
  localparam int DUP_W     = 2;
  localparam logic [DUP_W-1:0] DUP_LIMIT = 2'd3;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [PAY_W-1:0] pay_t;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_t;

  typedef struct packed {
    action_t    action;
    pay_t       payload;
    seq_t       ack_seq;
    logic       ack_intact;
  } in_item_t;

  typedef struct packed {
    logic       send_accepted;
    logic       tx_valid;
    seq_t       tx_seq;
    pay_t       tx_payload;
    logic       timer_stop;
    seq_t       stop_seq;
    logic       timer_start;
    seq_t       start_seq;
    logic       window_full;
  } out_item_t;

  typedef struct packed {
    logic       we;
    seq_t       addr;
    pay_t       data;
  } store_wr_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } win_status_t;

endpackage

>>> hw/rtl/sliding_window_sender_top.sv
// Sliding window sender, top level: input register, window control, packet
// store and result register. Depends on swsnd_pkg, swsnd_ctrl, swsnd_store
// and the assertion macros in sliding_window_sender_top_defines.svh.
//
// Usage:
//   - in channel (in_valid/in_ready/in_data) carries one event per transfer:
//     a send request, an ack arrival (with its upstream checksum verdict) or
//     a retransmit timer expiry.
//   - out channel (out_valid/out_ready/out_data) returns exactly one result
//     per event: send acceptance, packet to transmit, timer stop/start
//     commands and the window-full flag after the event.
//   - Path: each event is held in the input register, and its result in the
//     result register.
//   - Throughput: one event per cycle while out_ready holds; the only work per
//     event is a few sequence compares and one registered read of the 8-entry
//     packet store, addressed ahead at the base the next event will see.
//   - Reset (rst, synchronous): empties the window, clears the full flag and
//     the duplicate-ack count; store contents are left as they are.
//   - Receiver stall: the result register holds; the input register still
//     takes one more event, after which in_ready drops until out_ready.
`include "sliding_window_sender_top_defines.svh"

module sliding_window_sender_top #(
  parameter int WIN_PKTS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  swsnd_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swsnd_pkg::out_item_t  out_data
);

  // Input register stage.
  logic                   s1_valid;
  swsnd_pkg::in_item_t    s1_item;
  logic                   s1_fire;

  swsnd_pkg::pay_t        rd_data;
  swsnd_pkg::seq_t        rd_addr;
  swsnd_pkg::store_wr_t   wr;
  swsnd_pkg::out_item_t   result;
  swsnd_pkg::win_status_t status;

  // Process the held event whenever the result register is free or draining.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload register: capture on every transfer, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  swsnd_ctrl #(
    .WIN_PKTS (WIN_PKTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_fire),
    .item    (s1_item),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr      (wr),
    .result  (result),
    .status  (status)
  );

  swsnd_store #(
    .WIDTH (swsnd_pkg::PAY_W),
    .DEPTH (swsnd_pkg::SEQ_SPACE)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Result register: load on process, drop on transfer out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  // Input side stalls only behind a held event and a stalled result.
  `SWS_NEVER(a_ready_only_on_stall, clk, rst,
             !in_ready && !(s1_valid && out_valid && !out_ready))
  // A processed event always shows up in the result register.
  `SWS_ASSERT(a_fire_fills_output, clk, rst, s1_fire |=> out_valid)
  // A send that finds the window full is refused.
  `SWS_ASSERT(a_full_refuses_send, clk, rst,
              (s1_fire && status.full && (s1_item.action == swsnd_pkg::ACT_SEND))
              |=> (out_valid && !out_data.send_accepted && out_data.window_full))
  // A timeout on an empty window transmits nothing.
  `SWS_ASSERT(a_empty_timeout_silent, clk, rst,
              (s1_fire && status.empty && (s1_item.action == swsnd_pkg::ACT_TIMEOUT))
              |=> !out_data.tx_valid)

endmodule

>>> hw/rtl/swsnd_store.sv
// Generic RAM: one write port and one registered, write-first read port.
// Holds the packet store of the sliding window sender; no dependencies.
module swsnd_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Return the new word when the read hits the address being written.
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/swsnd_ctrl.sv
// Window control: base/next/full/duplicate state and per-event result.
// Depends on swsnd_pkg; reads the packet store (registered read) through rd_addr/rd_data.
module swsnd_ctrl #(
  parameter int WIN_PKTS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  swsnd_pkg::in_item_t     item,
  input  swsnd_pkg::pay_t         rd_data,
  output swsnd_pkg::seq_t         rd_addr,
  output swsnd_pkg::store_wr_t    wr,
  output swsnd_pkg::out_item_t    result,
  output swsnd_pkg::win_status_t  status
);

  localparam int SEQ_W = swsnd_pkg::SEQ_W;
  localparam int CW    = $clog2(swsnd_pkg::SEQ_SPACE + WIN_PKTS) + 2;

  swsnd_pkg::seq_t              base_seq, base_seq_next;
  swsnd_pkg::seq_t              next_seq, next_seq_next;
  logic                         full_flag, full_flag_next;
  logic [swsnd_pkg::DUP_W-1:0]  dup_count, dup_count_next, dup_inc;

  swsnd_pkg::seq_t              n_now, n_after_send, n_after_ack, ack_plus, next_plus;
  logic signed [CW-1:0]         win_s, ack_s, base_s, d_s, low_s;
  logic signed [CW-1:0]         n_now_s, n_send_s, n_ack_s;
  logic                         in_window, is_dup;

  assign win_s    = CW'(WIN_PKTS);
  assign ack_s    = $signed({{(CW-SEQ_W){1'b0}}, item.ack_seq});
  assign base_s   = $signed({{(CW-SEQ_W){1'b0}}, base_seq});
  assign d_s      = ack_s - base_s;
  assign low_s    = base_s - win_s;

  // Outstanding counts wrap with the sequence space.
  assign next_plus    = next_seq + SEQ_W'(1);
  assign ack_plus     = item.ack_seq + SEQ_W'(1);
  assign n_now        = next_seq - base_seq;
  assign n_after_send = next_plus - base_seq;
  assign n_after_ack  = next_seq - ack_plus;
  assign n_now_s      = $signed({{(CW-SEQ_W){1'b0}}, n_now});
  assign n_send_s     = $signed({{(CW-SEQ_W){1'b0}}, n_after_send});
  assign n_ack_s      = $signed({{(CW-SEQ_W){1'b0}}, n_after_ack});

  assign in_window = (!d_s[CW-1] && (d_s < win_s)) || (ack_s < low_s);
  assign is_dup    = (low_s < ack_s) && (ack_s < base_s);
  assign dup_inc   = dup_count + swsnd_pkg::DUP_W'(1);

  // Read ahead: address the base that the next event will see.
  assign rd_addr = step ? base_seq_next : base_seq;

  always_comb begin
    base_seq_next  = base_seq;
    next_seq_next  = next_seq;
    full_flag_next = full_flag;
    dup_count_next = dup_count;
    wr             = '0;
    result         = '0;
    case (item.action)
      swsnd_pkg::ACT_SEND: begin
        if (!full_flag) begin
          if (n_now_s >= win_s) begin
            full_flag_next = 1'b1;
          end else begin
            wr.we                = 1'b1;
            wr.addr              = next_seq;
            wr.data              = item.payload;
            result.send_accepted = 1'b1;
            result.tx_valid      = 1'b1;
            result.tx_seq        = next_seq;
            result.tx_payload    = item.payload;
            if (next_seq == base_seq) begin
              result.timer_start = 1'b1;
              result.start_seq   = next_seq;
            end
            next_seq_next = next_plus;
            if (n_send_s >= win_s) begin
              full_flag_next = 1'b1;
            end
          end
        end
      end
      swsnd_pkg::ACT_ACK: begin
        if (item.ack_intact) begin
          if (in_window) begin
            result.timer_stop = 1'b1;
            result.stop_seq   = base_seq;
            base_seq_next     = ack_plus;
            if (n_ack_s < win_s) begin
              full_flag_next = 1'b0;
            end
            if (n_after_ack != '0) begin
              result.timer_start = 1'b1;
              result.start_seq   = ack_plus;
            end
          end else if (is_dup) begin
            dup_count_next = dup_inc;
            if (dup_inc == swsnd_pkg::DUP_LIMIT) begin
              dup_count_next = '0;
              if (next_seq != base_seq) begin
                result.tx_valid   = 1'b1;
                result.tx_seq     = base_seq;
                result.tx_payload = rd_data;
              end
            end
          end
        end
      end
      swsnd_pkg::ACT_TIMEOUT: begin
        if (next_seq != base_seq) begin
          dup_count_next     = '0;
          result.timer_stop  = 1'b1;
          result.stop_seq    = base_seq;
          result.timer_start = 1'b1;
          result.start_seq   = base_seq;
          result.tx_valid    = 1'b1;
          result.tx_seq      = base_seq;
          result.tx_payload  = rd_data;
        end
      end
      default: begin
      end
    endcase
    result.window_full = full_flag_next;
    wr.we              = wr.we & step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq  <= '0;
      next_seq  <= '0;
      full_flag <= 1'b0;
      dup_count <= '0;
    end else if (step) begin
      base_seq  <= base_seq_next;
      next_seq  <= next_seq_next;
      full_flag <= full_flag_next;
      dup_count <= dup_count_next;
    end
  end

  assign status.full  = full_flag;
  assign status.empty = (next_seq == base_seq);

endmodule
